// ----- rtl/phr_pkg.sv -----
// Shared constants, types and 2/pi table for the float32 pi/2 argument reducer.
package phr_pkg;

	localparam int CHUNK_BITS = 24;
	localparam int TBL_MAX    = 66;
	localparam int WIN_W      = 224;
	localparam int FULL_W     = 352;
	// highest 2/pi bit index a window can reach
	localparam int KTOP       = 325;
	localparam int FRAC_W     = 221;
	localparam int Y_W        = 352;
	localparam int GRP_N      = 11;

	localparam logic [30:0] QUARTER_PI_ABS = 31'h3F490FDA;
	localparam logic [30:0] INF_ABS        = 31'h7F800000;
	localparam logic [63:0] QNAN_BITS      = 64'h7FF8000000000000;

	typedef logic [CHUNK_BITS-1:0] chunk_t;

	localparam chunk_t TWO_OVER_PI [TBL_MAX] = '{
		24'hA2F983, 24'h6E4E44, 24'h1529FC, 24'h2757D1, 24'hF534DD, 24'hC0DB62,
		24'h95993C, 24'h439041, 24'hFE5163, 24'hABDEBB, 24'hC561B7, 24'h246E3A,
		24'h424DD2, 24'hE00649, 24'h2EEA09, 24'hD1921C, 24'hFE1DEB, 24'h1CB129,
		24'hA73EE8, 24'h8235F5, 24'h2EBB44, 24'h84E99C, 24'h7026B4, 24'h5F7E41,
		24'h3991D6, 24'h398353, 24'h39F49C, 24'h845F8B, 24'hBDF928, 24'h3B1FF8,
		24'h97FFDE, 24'h05980F, 24'hEF2F11, 24'h8B5A0A, 24'h6D1F6D, 24'h367ECF,
		24'h27CB09, 24'hB74F46, 24'h3F669E, 24'h5FEA2D, 24'h7527BA, 24'hC7EBE5,
		24'hF17B3D, 24'h0739F7, 24'h8A5292, 24'hEA6BFB, 24'h5FB11F, 24'h8D5D08,
		24'h560330, 24'h46FC7B, 24'h6BABF0, 24'hCFBC20, 24'h9AF436, 24'h1DA9E3,
		24'h91615E, 24'hE61B08, 24'h659985, 24'h5F14A0, 24'h68408D, 24'hFFD880,
		24'h4D7327, 24'h310606, 24'h1556CA, 24'h73A8C9, 24'h60E27B, 24'hC08C6B
	};

	// pi/2 fraction limbs, little-endian; the integer limb is 1
	localparam logic [31:0] HALF_PI_LIMB [4] = '{
		32'h01B839A2, 32'h898CC517, 32'h42D18469, 32'h921FB544
	};

	// side information that rides along every stage
	typedef struct packed {
		logic        spec;
		logic [63:0] spec_bits;
		logic        neg;
		logic [2:0]  quad;
	} meta_t;

	// bit j holds 2/pi bit k = KTOP - j; bits past the table read as zero
	function automatic logic [FULL_W-1:0] inv_bits(input int words);
		logic [FULL_W-1:0] r;
		int k;
		int w;
		int pos;
		r = '0;
		for (int j = 0; j < FULL_W; j++) begin
			k = KTOP - j;
			if (k >= 1) begin
				w   = (k - 1) / CHUNK_BITS;
				pos = (k - 1) % CHUNK_BITS;
				if (w < words && w < TBL_MAX)
					r[j] = TWO_OVER_PI[w][CHUNK_BITS-1-pos];
			end
		end
		return r;
	endfunction

endpackage

// ----- rtl/payne_hanek_reduce_f32.sv -----
// Pipelined float32 argument reduction by pi/2 (exact fixed point, one rounding).
//
// Input stream s_axis: one word per item, tdata[31:0] = IEEE single x.
// Output stream m_axis: one word per item, tdata[2:0] = quadrant (n mod 8),
// tdata[66:3] = IEEE double of x - n*pi/2, tdata[71:67] = 0.
// Throughput is one item per cycle while the receiver keeps m_axis_tready
// high: every stage is a register and the multiplications are split into
// 32-bit partial products, so nothing loops.
// Stages: window select, 2/pi product, product sum, rounding to quadrant,
// pi/2 partial products, four stages of adders, coarse and fine leading-one
// search, then round and pack into the output register.
// Each stage has its own valid bit and loads when it is empty or when the
// stage after it moves, so bubbles close up while the receiver stalls and
// s_axis_tready stays high until every stage holds a word.
// A stalled output word holds; nothing is dropped or repeated.
// Reset (arst_n low) clears all valid bits; no item is in flight after it.
module payne_hanek_reduce_f32 import phr_pkg::*; #(
	parameter int TABLE_WORDS = 66
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,   // [31:0] x_bits
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [71:0] m_axis_tdata    // [2:0] quadrant, [66:3] reduced_bits, [71:67] zero
);

	localparam logic [FULL_W-1:0] INV_FULL = inv_bits(TABLE_WORDS);
	localparam int NSTG = 13;

	logic [NSTG:1] vld_q;
	logic [NSTG:1] adv;

	// Load a stage when it is empty or its word moves on
	always_comb begin
		adv[NSTG] = !vld_q[NSTG] || m_axis_tready;
		for (int k = NSTG - 1; k >= 1; k--) begin
			adv[k] = !vld_q[k] || adv[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (adv[1]) vld_q[1] <= s_axis_tvalid;
			for (int k = 2; k <= NSTG; k++) begin
				if (adv[k]) vld_q[k] <= vld_q[k-1];
			end
		end
	end

	assign s_axis_tready = adv[1];
	assign m_axis_tvalid = vld_q[NSTG];

	// ---------------- stage 1: decode, special cases, 2/pi window
	logic [7:0]        ef;
	logic [22:0]       mf;
	logic              is_small;
	logic              is_nonfin;
	logic [4:0]        p_top;
	logic [4:0]        sub_lz;
	logic [22:0]       sub_frac;
	logic [63:0]       widened;
	logic [7:0]        win_shift;
	logic [FULL_W-1:0] win_full;

	assign ef        = s_axis_tdata[30:23];
	assign mf        = s_axis_tdata[22:0];
	assign is_small  = s_axis_tdata[30:0] <= QUARTER_PI_ABS;
	assign is_nonfin = s_axis_tdata[30:0] >= INF_ABS;
	assign win_shift = 8'd254 - ef;
	assign win_full  = INV_FULL >> win_shift;

	// Widen the small input exactly, normalizing subnormals
	always_comb begin
		p_top = '0;
		for (int b = 0; b < 23; b++) begin
			if (mf[b]) p_top = 5'(b);
		end
		sub_lz   = 5'd22 - p_top;
		sub_frac = mf << (sub_lz + 5'd1);
		if (ef == 8'd0) begin
			if (mf == 23'd0)
				widened = {s_axis_tdata[31], 63'd0};
			else
				widened = {s_axis_tdata[31], 11'(p_top) + 11'd874, sub_frac, 29'd0};
		end else begin
			widened = {s_axis_tdata[31], 11'(ef) + 11'd896, mf, 29'd0};
		end
	end

	logic [23:0]      m_s1;
	logic [WIN_W-1:0] win_s1;
	meta_t            meta_s1;

	always_ff @(posedge clk) begin
		if (adv[1]) begin
			m_s1              <= {1'b1, mf};
			win_s1            <= win_full[WIN_W-1:0];
			meta_s1.spec      <= is_small || is_nonfin;
			meta_s1.spec_bits <= is_nonfin ? QNAN_BITS : widened;
			meta_s1.neg       <= s_axis_tdata[31];
			meta_s1.quad      <= '0;
		end
	end

	// ---------------- stage 2: mantissa times window limbs
	logic [55:0] pp_s2 [7];
	meta_t       meta_s2;

	always_ff @(posedge clk) begin
		if (adv[2]) begin
			for (int i = 0; i < 7; i++) begin
				pp_s2[i] <= 56'(m_s1) * 56'(win_s1[32*i +: 32]);
			end
			meta_s2 <= meta_s1;
		end
	end

	// ---------------- stage 3: sum even and odd partial products
	logic [255:0]     ev3;
	logic [255:0]     od3;
	logic [WIN_W-1:0] prod_s3;
	meta_t            meta_s3;

	assign ev3 = {8'd0, pp_s2[6], 8'd0, pp_s2[4], 8'd0, pp_s2[2], 8'd0, pp_s2[0]};
	assign od3 = {32'd0, 8'd0, pp_s2[5], 8'd0, pp_s2[3], 8'd0, pp_s2[1], 32'd0};

	always_ff @(posedge clk) begin
		if (adv[3]) begin
			prod_s3 <= WIN_W'(ev3 + od3);
			meta_s3 <= meta_s2;
		end
	end

	// ---------------- stage 4: round to nearest quadrant, fold fraction
	logic              half4;
	logic [2:0]        n4;
	logic [FRAC_W-1:0] gl4;
	logic [FRAC_W-1:0] g_s4;
	meta_t             meta_s4;

	assign half4 = prod_s3[FRAC_W-1];
	assign n4    = prod_s3[WIN_W-1:FRAC_W] + {2'b0, half4};
	assign gl4   = prod_s3[FRAC_W-1:0];

	always_ff @(posedge clk) begin
		if (adv[4]) begin
			g_s4              <= half4 ? (~gl4 + FRAC_W'(1)) : gl4;
			meta_s4.spec      <= meta_s3.spec;
			meta_s4.spec_bits <= meta_s3.spec_bits;
			meta_s4.neg       <= half4 ^ meta_s3.neg;
			meta_s4.quad      <= meta_s3.neg ? (3'd0 - n4) : n4;
		end
	end

	// ---------------- stage 5: fraction times pi/2 limbs
	logic [WIN_W-1:0]  gp5;
	logic [63:0]       pq_s5 [7][4];
	logic [FRAC_W-1:0] g_s5;
	meta_t             meta_s5;

	assign gp5 = {3'b0, g_s4};

	always_ff @(posedge clk) begin
		if (adv[5]) begin
			for (int i = 0; i < 7; i++) begin
				for (int j = 0; j < 4; j++) begin
					pq_s5[i][j] <= 64'(gp5[32*i +: 32]) * 64'(HALF_PI_LIMB[j]);
				end
			end
			g_s5    <= g_s4;
			meta_s5 <= meta_s4;
		end
	end

	// ---------------- stage 6: one row per pi/2 limb
	logic [255:0]      row_s6 [4];
	logic [FRAC_W-1:0] g_s6;
	meta_t             meta_s6;

	always_ff @(posedge clk) begin
		if (adv[6]) begin
			for (int j = 0; j < 4; j++) begin
				row_s6[j] <= {pq_s5[6][j], pq_s5[4][j], pq_s5[2][j], pq_s5[0][j]}
				           + {32'd0, pq_s5[5][j], pq_s5[3][j], pq_s5[1][j], 32'd0};
			end
			g_s6    <= g_s5;
			meta_s6 <= meta_s5;
		end
	end

	// ---------------- stages 7 to 9: add rows into the exact product
	logic [Y_W-1:0] a_s7;
	logic [Y_W-1:0] b_s7;
	logic [Y_W-1:0] c_s7;
	meta_t          meta_s7;
	logic [Y_W-1:0] ab_s8;
	logic [Y_W-1:0] c_s8;
	meta_t          meta_s8;
	logic [Y_W-1:0] y_s9;
	meta_t          meta_s9;

	always_ff @(posedge clk) begin
		if (adv[7]) begin
			a_s7    <= Y_W'(row_s6[0]) + (Y_W'(row_s6[1]) << 32);
			b_s7    <= (Y_W'(row_s6[2]) << 64) + (Y_W'(row_s6[3]) << 96);
			c_s7    <= Y_W'(g_s6) << 128;
			meta_s7 <= meta_s6;
		end
		if (adv[8]) begin
			ab_s8   <= a_s7 + b_s7;
			c_s8    <= c_s7;
			meta_s8 <= meta_s7;
		end
		if (adv[9]) begin
			y_s9    <= ab_s8 + c_s8;
			meta_s9 <= meta_s8;
		end
	end

	// ---------------- stage 10: find highest nonzero 32-bit group
	logic [GRP_N-1:0] nz10;
	logic [GRP_N-1:0] pre10;
	logic [3:0]       grp10;

	always_comb begin
		grp10 = '0;
		for (int q = 0; q < GRP_N; q++) begin
			nz10[q] = |y_s9[32*q +: 32];
			if (nz10[q]) grp10 = 4'(q);
		end
		pre10[0] = nz10[0];
		for (int q = 1; q < GRP_N; q++) begin
			pre10[q] = pre10[q-1] | nz10[q];
		end
	end

	logic [Y_W-1:0]   y_s10;
	logic [3:0]       grp_s10;
	logic [GRP_N-1:0] pre_s10;
	meta_t            meta_s10;

	always_ff @(posedge clk) begin
		if (adv[10]) begin
			y_s10    <= y_s9;
			grp_s10  <= grp10;
			pre_s10  <= pre10;
			meta_s10 <= meta_s9;
		end
	end

	// ---------------- stage 11: coarse shift to a 96-bit window
	logic [Y_W+63:0] yp11;
	logic [95:0]     win_s11;
	logic            sticky_s11;
	logic            any_s11;
	logic [3:0]      grp_s11;
	meta_t           meta_s11;

	assign yp11 = {y_s10, 64'd0};

	always_ff @(posedge clk) begin
		if (adv[11]) begin
			win_s11    <= yp11[{grp_s10, 5'b0} +: 96];
			sticky_s11 <= (grp_s10 >= 4'd3) ? pre_s10[grp_s10 - 4'd3] : 1'b0;
			any_s11    <= pre_s10[GRP_N-1];
			grp_s11    <= grp_s10;
			meta_s11   <= meta_s10;
		end
	end

	// ---------------- stage 12: fine normalize, split mantissa and guard
	logic [4:0]  hb12;
	logic [4:0]  lz12;
	logic [95:0] sh12;

	always_comb begin
		hb12 = '0;
		for (int b = 0; b < 32; b++) begin
			if (win_s11[64+b]) hb12 = 5'(b);
		end
		lz12 = 5'd31 - hb12;
		sh12 = win_s11 << lz12;
	end

	logic [52:0] mant_s12;
	logic        guard_s12;
	logic        sticky_s12;
	logic        any_s12;
	logic [8:0]  h_s12;
	meta_t       meta_s12;

	always_ff @(posedge clk) begin
		if (adv[12]) begin
			mant_s12   <= sh12[95:43];
			guard_s12  <= sh12[42];
			sticky_s12 <= sticky_s11 | (|sh12[41:0]);
			any_s12    <= any_s11;
			h_s12      <= {grp_s11, 5'b0} + 9'd31 - 9'(lz12);
			meta_s12   <= meta_s11;
		end
	end

	// ---------------- stage 13: round to nearest even, pack, output register
	logic        inc13;
	logic [53:0] m54;
	logic [51:0] frac13;
	logic [10:0] exp13;
	logic [63:0] bits13;

	always_comb begin
		inc13 = guard_s12 & (sticky_s12 | mant_s12[0]);
		m54   = {1'b0, mant_s12} + 54'(inc13);
		if (m54[53]) begin
			frac13 = '0;
			exp13  = 11'(h_s12) + 11'd675;
		end else begin
			frac13 = m54[51:0];
			exp13  = 11'(h_s12) + 11'd674;
		end
		if (meta_s12.spec)
			bits13 = meta_s12.spec_bits;
		else if (!any_s12)
			bits13 = '0;
		else
			bits13 = {meta_s12.neg, exp13, frac13};
	end

	logic [2:0]  quad_s13;
	logic [63:0] bits_s13;

	always_ff @(posedge clk) begin
		if (adv[13]) begin
			quad_s13 <= meta_s12.spec ? 3'd0 : meta_s12.quad;
			bits_s13 <= bits13;
		end
	end

	assign m_axis_tdata = {5'd0, bits_s13, quad_s13};

	// ---------------- checks
	// folded fraction never exceeds one half
	a_frac_half: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_q[4] && !meta_s4.spec) |-> (!g_s4[FRAC_W-1] || g_s4[FRAC_W-2:0] == '0))
		else $error("folded fraction above one half");

	// coarse window always starts with a nonzero group
	a_coarse_lead: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_q[11] && any_s11 && !meta_s11.spec) |-> (win_s11[95:64] != '0))
		else $error("coarse window lost its leading group");

	// normalized mantissa has its hidden bit
	a_norm_lead: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_q[12] && any_s12 && !meta_s12.spec) |-> mant_s12[52])
		else $error("mantissa not normalized");

endmodule

// ----- tb/sv/payne_hanek_reduce_f32_tb.sv -----
// Self-checking testbench for the pipelined float32 pi/2 argument reducer.
module payne_hanek_reduce_f32_tb;
	import phr_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int N_RANDOM    = 1130;
	localparam int QUIET_TAIL  = 150;
	localparam int CYCLE_LIMIT = 200000;
	localparam int DRAIN_WAIT  = 40;

	typedef struct {
		logic [31:0] x;
		bit          typed;
		logic [2:0]  quad;
		logic [63:0] bits;
	} stim_row_t;

	typedef struct {
		logic [31:0] x;
		logic [2:0]  quad;
		logic [63:0] bits;
	} red_word_t;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [71:0] m_axis_tdata;

	red_word_t pending_q[$];
	int        fail_cnt;
	int        sent_cnt;
	int        cycle_cnt;
	bit        quiet;
	bit        long_hold;

	payne_hanek_reduce_f32 DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata)
	);

	// directed edge cases; typed rows carry their result
	stim_row_t edge_rows[] = '{
		'{32'h00000000, 1'b1, 3'd0, 64'h0000000000000000},
		'{32'h80000000, 1'b1, 3'd0, 64'h8000000000000000},
		'{32'h3F000000, 1'b1, 3'd0, 64'h3FE0000000000000},
		'{32'h7F800000, 1'b1, 3'd0, QNAN_BITS},
		'{32'hFF800000, 1'b1, 3'd0, QNAN_BITS},
		'{32'h7FC00000, 1'b1, 3'd0, QNAN_BITS},
		'{32'hFFFFFFFF, 1'b1, 3'd0, QNAN_BITS},
		'{32'h7F800001, 1'b1, 3'd0, QNAN_BITS},
		'{32'h00000001, 1'b0, 3'd0, 64'h0},
		'{32'h807FFFFF, 1'b0, 3'd0, 64'h0},
		'{32'h00800000, 1'b0, 3'd0, 64'h0},
		'{32'h3F490FDA, 1'b0, 3'd0, 64'h0},
		'{32'hBF490FDA, 1'b0, 3'd0, 64'h0},
		'{32'h3F490FDB, 1'b0, 3'd0, 64'h0},
		'{32'hBF490FDB, 1'b0, 3'd0, 64'h0},
		'{32'h3F800000, 1'b0, 3'd0, 64'h0},
		'{32'hBF800000, 1'b0, 3'd0, 64'h0},
		'{32'h3FC90FDB, 1'b0, 3'd0, 64'h0},
		'{32'h40490FDB, 1'b0, 3'd0, 64'h0},
		'{32'h4DC90FDB, 1'b0, 3'd0, 64'h0},
		'{32'hCDC90FDB, 1'b0, 3'd0, 64'h0},
		'{32'h4B7FFFFF, 1'b0, 3'd0, 64'h0},
		'{32'h7F7FFFFF, 1'b0, 3'd0, 64'h0},
		'{32'hFF7FFFFF, 1'b0, 3'd0, 64'h0},
		'{32'h5EFFFFFF, 1'b0, 3'd0, 64'h0}
	};

	// exact reduction: quadrant and rounded double remainder
	function automatic void reduce_by_half_pi(input logic [31:0] xb,
			output logic [2:0] quad, output logic [63:0] bits);
		logic [30:0]  ax;
		logic [22:0]  mf;
		logic [23:0]  m;
		logic [223:0] win;
		logic [247:0] prod;
		logic [220:0] g;
		logic [128:0] hp;
		logic [383:0] y;
		logic [383:0] ys;
		logic [52:0]  mant;
		logic [53:0]  mr;
		logic [2:0]   n;
		logic         yneg;
		int           kstart;
		int           k;
		int           h;
		int           p;
		ax = xb[30:0];
		mf = xb[22:0];
		quad = 3'd0;
		// small magnitude: widen exactly
		if (ax <= QUARTER_PI_ABS) begin
			if (ax == 0) begin
				bits = {xb[31], 63'b0};
			end else if (xb[30:23] == 0) begin
				p = 22;
				while (p > 0 && !mf[p]) p--;
				bits = {xb[31], 11'(p - 149 + 1023), 52'(64'(mf) << (52 - p))};
			end else begin
				bits = {xb[31], 11'(xb[30:23] + 896), mf, 29'b0};
			end
			return;
		end
		if (ax >= INF_ABS) begin
			bits = QNAN_BITS;
			return;
		end
		m = {1'b1, mf};
		kstart = int'(xb[30:23]) - 152;
		// window of 2/pi bits, zero past the table
		for (int i = 0; i < 224; i++) begin
			k = kstart + 223 - i;
			win[i] = 1'b0;
			if (k >= 1 && (k - 1) / CHUNK_BITS < 66)
				win[i] = TWO_OVER_PI[(k - 1) / CHUNK_BITS][CHUNK_BITS - 1 - (k - 1) % CHUNK_BITS];
		end
		prod = {224'b0, m} * {24'b0, win};
		n = prod[223:221];
		g = prod[220:0];
		if (prod[220]) begin
			g = -g;
			n = n + 3'd1;
		end
		yneg = prod[220] ^ xb[31];
		if (xb[31]) n = -n;
		quad = n;
		hp = {1'b1, HALF_PI_LIMB[3], HALF_PI_LIMB[2], HALF_PI_LIMB[1], HALF_PI_LIMB[0]};
		y = {163'b0, g} * {255'b0, hp};
		if (y == 0) begin
			bits = 64'h0;
			return;
		end
		h = 383;
		while (!y[h]) h--;
		// normalize, then round to nearest even
		ys = y << (383 - h);
		mant = ys[383:331];
		if (ys[330] && ((|ys[329:0]) || mant[0])) begin
			mr = {1'b0, mant} + 54'd1;
			if (mr[53]) begin
				mant = mr[53:1];
				h++;
			end else begin
				mant = mr[52:0];
			end
		end
		bits = {yneg, 11'(h - 349 + 1023), mant[51:0]};
	endfunction

	// offer one word, hold until taken, then record its expectation
	task automatic send_word(input logic [31:0] x, input bit typed,
			input logic [2:0] tq, input logic [63:0] tb);
		red_word_t e;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= x;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		e.x = x;
		if (typed) begin
			e.quad = tq;
			e.bits = tb;
		end else begin
			reduce_by_half_pi(x, e.quad, e.bits);
		end
		pending_q.push_back(e);
		sent_cnt++;
		if (!quiet && $urandom_range(0, 3) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
	endtask

	// random operand, weighted toward the reduction path
	function automatic logic [31:0] rand_operand();
		logic [31:0] r;
		int          sel;
		r = $urandom;
		sel = $urandom_range(0, 99);
		if (sel < 40)
			r[30:23] = 8'($urandom_range(127, 160));
		else if (sel < 55)
			r[30:23] = 8'($urandom_range(161, 254));
		else if (sel < 65)
			r[30:23] = 8'($urandom_range(0, 126));
		else if (sel < 70)
			r[30:23] = 8'hFF;
		else if (sel < 75)
			r[30:0] = QUARTER_PI_ABS + 31'($urandom_range(0, 3)) - 31'd1;
		return r;
	endfunction

	always #5 clk = ~clk;

	// cycle limit
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// receiver: random stall bursts, one long hold-off
	initial begin
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (!long_hold && sent_cnt > 300) begin
				long_hold = 1'b1;
				m_axis_tready <= 1'b0;
				repeat (60) @(posedge clk);
			end
			if (!quiet && $urandom_range(0, 4) == 0) begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(1, 4)) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
		end
	end

	// compare each taken word with the oldest expectation
	always @(posedge clk) begin
		red_word_t e;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_q.size() == 0) begin
				$display("%0t: unexpected word %h", $time, m_axis_tdata);
				fail_cnt++;
			end else begin
				e = pending_q.pop_front();
				if (m_axis_tdata[2:0] !== e.quad) begin
					$display("%0t: x=%h quadrant expected %0d actual %0d",
						$time, e.x, e.quad, m_axis_tdata[2:0]);
					fail_cnt++;
				end
				if (m_axis_tdata[66:3] !== e.bits) begin
					$display("%0t: x=%h reduced expected %h actual %h",
						$time, e.x, e.bits, m_axis_tdata[66:3]);
					fail_cnt++;
				end
				if (m_axis_tdata[71:67] !== 5'b0) begin
					$display("%0t: x=%h pad expected 0 actual %h",
						$time, e.x, m_axis_tdata[71:67]);
					fail_cnt++;
				end
			end
		end
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		fail_cnt = 0;
		sent_cnt = 0;
		cycle_cnt = 0;
		quiet = 1'b0;
		long_hold = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (edge_rows[i])
			send_word(edge_rows[i].x, edge_rows[i].typed, edge_rows[i].quad, edge_rows[i].bits);
		for (int i = 0; i < N_RANDOM; i++) begin
			if (i == N_RANDOM - QUIET_TAIL) quiet = 1'b1;
			send_word(rand_operand(), 1'b0, 3'd0, 64'h0);
		end
		s_axis_tvalid <= 1'b0;
		// drain
		while (pending_q.size() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (fail_cnt == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
